@@ rtl/periodic_cell_neighbor_generator_macros.svh @@
// Assertion macros used by the neighbor generator top level.
`ifndef PERIODIC_CELL_NEIGHBOR_GENERATOR_MACROS_SVH
`define PERIODIC_CELL_NEIGHBOR_GENERATOR_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define PCNG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define PCNG_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  `PCNG_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

@@ rtl/pcng_pkg.sv @@
// Types and constants shared by the periodic cell neighbor generator.
`default_nettype none
package pcng_pkg;

  localparam int NumSlots        = 26;
  localparam int MaxCellsPerAxis = 64;

  localparam int CoordW = 6;
  localparam int SizeW  = 7;
  localparam int SlotW  = 5;
  localparam int IndexW = 18;
  localparam int RowW   = 12;
  localparam int PlaneW = 13;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgSizeX = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSizeY = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSizeZ = 2'd2;

  typedef enum logic [1:0] {
    SelMinus  = 2'd0,
    SelCenter = 2'd1,
    SelPlus   = 2'd2
  } sel_e;

  typedef struct packed {
    logic [CoordW-1:0] cell_x;
    logic [CoordW-1:0] cell_y;
    logic [CoordW-1:0] cell_z;
  } in_item_t;

  typedef struct packed {
    logic [SlotW-1:0]  slot;
    logic [IndexW-1:0] neighbor_index;
    logic              bad_coordinate;
    logic              last;
  } out_item_t;

  // Classified request: wrapped x values and row and plane offsets,
  // each indexed by sel_e.
  typedef struct packed {
    logic [2:0][CoordW-1:0] xs;
    logic [2:0][RowW-1:0]   yoff;
    logic [2:0][IndexW-1:0] zoff;
    logic                   bad;
  } cls_item_t;

endpackage
`default_nettype wire

@@ rtl/periodic_cell_neighbor_generator.sv @@
// Top level of the periodic 26-neighbor cell index generator.
`default_nettype none
`include "periodic_cell_neighbor_generator_macros.svh"
// Takes one cell coordinate per push and returns the linear indices
// z*X*Y + y*X + x of its 26 periodic neighbors, one result per cycle in slot
// order while the output is popped, with last set on slot 25. A coordinate not
// below its axis size (sizes above 64 count as 64) returns one result flagged
// bad_coordinate. A good request yields 26 results and a bad one a single
// result; the slot counter in the back end steps through them. The front end
// (range check, wrap, offset multiplies) registers the wrapped coordinates and
// then the offset products, and keeps accepting requests into a
// QueueDepth-entry queue while earlier requests are still being expanded. Size
// registers take effect for requests pushed after the write.
module periodic_cell_neighbor_generator #(
  parameter int QueueDepth = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pcng_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pcng_pkg::SizeW-1:0]   cfg_data_i,
  input  logic                         push,
  output logic                         full,
  input  pcng_pkg::in_item_t           in_item_i,
  output logic                         empty,
  input  logic                         pop,
  output pcng_pkg::out_item_t          out_item_o
);
  import pcng_pkg::*;

  logic      q_push, q_full, q_pop, q_empty;
  cls_item_t q_wr_item, q_rd_item;

  pcng_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .q_push_o   (q_push),
    .q_item_o   (q_wr_item),
    .q_full_i   (q_full)
  );

  pcng_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_wr_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_rd_item),
    .empty_o (q_empty)
  );

  pcng_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_item_i   (q_rd_item),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  `PCNG_ASSERT_IMPLIES(a_no_overflow, q_push, !q_full, "queue written while full")
  `PCNG_ASSERT_IMPLIES(a_no_underflow, q_pop, !q_empty, "queue read while empty")
  `PCNG_ASSERT_IMPLIES(a_bad_single, !empty && out_item_o.bad_coordinate,
                       out_item_o.last && (out_item_o.slot == '0),
                       "bad coordinate result not a single last item")
  `PCNG_ASSERT_IMPLIES(a_last_slot, !empty && out_item_o.last && !out_item_o.bad_coordinate,
                       out_item_o.slot == SlotW'(NumSlots - 1),
                       "last set before the final slot")

endmodule
`default_nettype wire

@@ rtl/pcng_front.sv @@
// Front end: size registers, request intake, range check and offset products.
`default_nettype none
module pcng_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pcng_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pcng_pkg::SizeW-1:0]      cfg_data_i,
  input  logic                            push,
  output logic                            full,
  input  pcng_pkg::in_item_t              in_item_i,
  output logic                            q_push_o,
  output pcng_pkg::cls_item_t             q_item_o,
  input  logic                            q_full_i
);
  import pcng_pkg::*;

  typedef struct packed {
    logic [2:0][CoordW-1:0] x;
    logic [2:0][CoordW-1:0] y;
    logic [2:0][CoordW-1:0] z;
    logic                   bad;
  } wrap_t;

  logic [SizeW-1:0]  size_x_q, size_y_q, size_z_q;
  logic [SizeW-1:0]  eff_x, eff_y, eff_z;
  logic [PlaneW-1:0] sxy_q;
  logic              s1_v_q, s2_v_q;
  wrap_t             s1_q, s1_d;
  cls_item_t         s2_q, s2_d;
  logic              s1_take, s2_take, s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= 7'd8;
      size_y_q <= 7'd8;
      size_z_q <= 7'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSizeX: size_x_q <= cfg_data_i;
        CfgSizeY: size_y_q <= cfg_data_i;
        CfgSizeZ: size_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Saturate each axis to the largest supported size.
  assign eff_x = (size_x_q > SizeW'(MaxCellsPerAxis)) ? SizeW'(MaxCellsPerAxis) : size_x_q;
  assign eff_y = (size_y_q > SizeW'(MaxCellsPerAxis)) ? SizeW'(MaxCellsPerAxis) : size_y_q;
  assign eff_z = (size_z_q > SizeW'(MaxCellsPerAxis)) ? SizeW'(MaxCellsPerAxis) : size_z_q;

  always_ff @(posedge clk_i) begin
    sxy_q <= {6'b0, eff_x} * {6'b0, eff_y};
  end

  assign s2_ready = !s2_v_q || !q_full_i;
  assign s2_take  = s1_v_q && s2_ready;
  assign full     = s1_v_q && !s2_ready;
  assign s1_take  = push && !full;

  always_comb begin
    s1_d.bad = ({1'b0, in_item_i.cell_x} >= eff_x) ||
               ({1'b0, in_item_i.cell_y} >= eff_y) ||
               ({1'b0, in_item_i.cell_z} >= eff_z);
    s1_d.x[SelCenter] = in_item_i.cell_x;
    s1_d.y[SelCenter] = in_item_i.cell_y;
    s1_d.z[SelCenter] = in_item_i.cell_z;
    s1_d.x[SelPlus] = (({1'b0, in_item_i.cell_x} + 7'd1) >= eff_x) ? '0 :
                      in_item_i.cell_x + 6'd1;
    s1_d.y[SelPlus] = (({1'b0, in_item_i.cell_y} + 7'd1) >= eff_y) ? '0 :
                      in_item_i.cell_y + 6'd1;
    s1_d.z[SelPlus] = (({1'b0, in_item_i.cell_z} + 7'd1) >= eff_z) ? '0 :
                      in_item_i.cell_z + 6'd1;
    s1_d.x[SelMinus] = (in_item_i.cell_x == '0) ? CoordW'(eff_x - 7'd1) :
                       in_item_i.cell_x - 6'd1;
    s1_d.y[SelMinus] = (in_item_i.cell_y == '0) ? CoordW'(eff_y - 7'd1) :
                       in_item_i.cell_y - 6'd1;
    s1_d.z[SelMinus] = (in_item_i.cell_z == '0) ? CoordW'(eff_z - 7'd1) :
                       in_item_i.cell_z - 6'd1;
  end

  always_comb begin
    s2_d.bad = s1_q.bad;
    s2_d.xs  = s1_q.x;
    for (int i = 0; i < 3; i++) begin
      s2_d.yoff[i] = {6'b0, s1_q.y[i]} * {5'b0, eff_x};
      s2_d.zoff[i] = {12'b0, s1_q.z[i]} * {5'b0, sxy_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_v_q <= 1'b1;
      end else if (s2_take) begin
        s1_v_q <= 1'b0;
      end
      if (s2_take) begin
        s2_v_q <= 1'b1;
      end else if (s2_ready) begin
        s2_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take) begin
      s1_q <= s1_d;
    end
    if (s2_take) begin
      s2_q <= s2_d;
    end
  end

  assign q_push_o = s2_v_q && !q_full_i;
  assign q_item_o = s2_q;

endmodule
`default_nettype wire

@@ rtl/pcng_queue.sv @@
// Short queue of classified requests between front end and slot sequencer.
`default_nettype none
module pcng_queue #(
  parameter int Depth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pcng_pkg::cls_item_t item_i,
  output logic                full_o,
  input  logic                pop_i,
  output pcng_pkg::cls_item_t item_o,
  output logic                empty_o
);
  import pcng_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cls_item_t           mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/pcng_back.sv @@
// Back end: steps through the 26 slots and holds the result in an output register.
`default_nettype none
module pcng_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pcng_pkg::cls_item_t q_item_i,
  input  logic                q_empty_i,
  output logic                q_pop_o,
  output logic                empty,
  input  logic                pop,
  output pcng_pkg::out_item_t out_item_o
);
  import pcng_pkg::*;

  typedef struct packed {
    sel_e xs;
    sel_e ys;
    sel_e zs;
  } slot_sel_t;

  function automatic slot_sel_t slot_sel(logic [SlotW-1:0] k);
    slot_sel_t r;
    r = '{xs: SelCenter, ys: SelCenter, zs: SelCenter};
    unique case (k[2:0])
      3'd0: r = '{xs: SelMinus,  ys: SelPlus,   zs: SelCenter};
      3'd1: r = '{xs: SelMinus,  ys: SelCenter, zs: SelCenter};
      3'd2: r = '{xs: SelMinus,  ys: SelMinus,  zs: SelCenter};
      3'd3: r = '{xs: SelCenter, ys: SelPlus,   zs: SelCenter};
      3'd4: r = '{xs: SelCenter, ys: SelMinus,  zs: SelCenter};
      3'd5: r = '{xs: SelPlus,   ys: SelPlus,   zs: SelCenter};
      3'd6: r = '{xs: SelPlus,   ys: SelCenter, zs: SelCenter};
      3'd7: r = '{xs: SelPlus,   ys: SelMinus,  zs: SelCenter};
      default: ;
    endcase
    unique case (k[4:3])
      2'd0: r.zs = SelCenter;
      2'd1: r.zs = SelPlus;
      2'd2: r.zs = SelMinus;
      default: begin
        // straight up for the first vertical slot, straight down for the second
        r.xs = SelCenter;
        r.ys = SelCenter;
        r.zs = k[0] ? SelMinus : SelPlus;
      end
    endcase
    return r;
  endfunction

  logic [SlotW-1:0] slot_q;
  logic             out_v_q;
  out_item_t        out_q, out_d;
  slot_sel_t        sel;
  logic             load, item_done;

  assign sel       = slot_sel(slot_q);
  assign load      = !q_empty_i && (!out_v_q || pop);
  assign item_done = q_item_i.bad || (slot_q == SlotW'(NumSlots - 1));
  assign q_pop_o   = load && item_done;

  always_comb begin
    if (q_item_i.bad) begin
      out_d.slot           = '0;
      out_d.neighbor_index = '0;
      out_d.bad_coordinate = 1'b1;
      out_d.last           = 1'b1;
    end else begin
      out_d.slot           = slot_q;
      out_d.neighbor_index = q_item_i.zoff[sel.zs] +
                             {6'b0, q_item_i.yoff[sel.ys]} +
                             {12'b0, q_item_i.xs[sel.xs]};
      out_d.bad_coordinate = 1'b0;
      out_d.last           = (slot_q == SlotW'(NumSlots - 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (load) begin
        out_v_q <= 1'b1;
        slot_q  <= item_done ? '0 : slot_q + 1'b1;
      end else if (pop) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign empty      = !out_v_q;
  assign out_item_o = out_q;

endmodule
`default_nettype wire

@@ tb/sv/periodic_cell_neighbor_generator_tb.sv @@
// Testbench for the periodic 26-neighbor cell index generator.
`timescale 1ns / 100ps

module periodic_cell_neighbor_generator_tb;
  import pcng_pkg::*;

  localparam int PlaneSlots  = 8;
  localparam int UpRingEnd   = 16;
  localparam int DownRingEnd = 24;
  localparam int SlotUp      = 24;
  localparam int SettleCycles = 8;
  localparam int LongHoldCycles = 300;
  localparam int PhaseItems  = 50;
  localparam int RandomPhases = 8;
  localparam int CycleLimit  = 800000;
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [SizeW-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  in_item_t in_item = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t out_item;

  // Copy of the size registers as the block should hold them.
  logic [SizeW-1:0] size_x_r = 7'd8;
  logic [SizeW-1:0] size_y_r = 7'd8;
  logic [SizeW-1:0] size_z_r = 7'd8;

  in_item_t request_q[$];
  out_item_t neighbor_q[$];
  logic offering = 1'b0;
  logic calm = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  int holds_req = 0;
  int holds_done = 0;
  int error_count = 0;
  int cycle_count = 0;

  periodic_cell_neighbor_generator u_top (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .push      (push),
    .full      (full),
    .in_item_i (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp_size(logic [SizeW-1:0] s);
    return (s > MaxCellsPerAxis) ? MaxCellsPerAxis : int'(s);
  endfunction

  function automatic int move_axis(int c, int d, int s);
    if (d > 0) return (c + 1 >= s) ? 0 : c + 1;
    if (d < 0) return (c == 0) ? s - 1 : c - 1;
    return c;
  endfunction

  // Expand one cell into its neighbor indices in slot order.
  function automatic void expand_neighbors(in_item_t req);
    int sx, sy, sz, nx, ny, nz, dx, dy, dz, idx;
    out_item_t res;
    sx = clamp_size(size_x_r);
    sy = clamp_size(size_y_r);
    sz = clamp_size(size_z_r);
    res = '0;
    if (req.cell_x >= sx || req.cell_y >= sy || req.cell_z >= sz) begin
      res.bad_coordinate = 1'b1;
      res.last = 1'b1;
      neighbor_q.push_back(res);
      return;
    end
    for (int k = 0; k < NumSlots; k++) begin
      dx = 0;
      dy = 0;
      if (k < DownRingEnd) begin
        case (k % PlaneSlots)
          0: begin dx = -1; dy = 1; end
          1: begin dx = -1; dy = 0; end
          2: begin dx = -1; dy = -1; end
          3: begin dx = 0; dy = 1; end
          4: begin dx = 0; dy = -1; end
          5: begin dx = 1; dy = 1; end
          6: begin dx = 1; dy = 0; end
          default: begin dx = 1; dy = -1; end
        endcase
      end
      if (k < PlaneSlots) dz = 0;
      else if (k < UpRingEnd) dz = 1;
      else if (k < DownRingEnd) dz = -1;
      else if (k == SlotUp) dz = 1;
      else dz = -1;
      nx = move_axis(int'(req.cell_x), dx, sx);
      ny = move_axis(int'(req.cell_y), dy, sy);
      nz = move_axis(int'(req.cell_z), dz, sz);
      idx = nz * sx * sy + ny * sx + nx;
      res.slot = SlotW'(k);
      res.neighbor_index = IndexW'(idx);
      res.bad_coordinate = 1'b0;
      res.last = (k == NumSlots - 1);
      neighbor_q.push_back(res);
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [SizeW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      CfgSizeX: size_x_r = val;
      CfgSizeY: size_y_r = val;
      CfgSizeZ: size_z_r = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_sizes(int sx, int sy, int sz);
    write_reg(CfgSizeX, SizeW'(sx));
    write_reg(CfgSizeY, SizeW'(sy));
    write_reg(CfgSizeZ, SizeW'(sz));
  endtask

  task automatic queue_cell(int x, int y, int z);
    in_item_t it;
    it.cell_x = CoordW'(x);
    it.cell_y = CoordW'(y);
    it.cell_z = CoordW'(z);
    request_q.push_back(it);
  endtask

  // Hold until every item is sent and answered, then let the front end settle.
  task automatic wait_drained();
    while (request_q.size() != 0 || offering || neighbor_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 127);
    if (r < 4) return $urandom_range(1, 3);
    return $urandom_range(1, 64);
  endfunction

  // Mostly in-range coordinates, leaning toward the wrap edges.
  function automatic int pick_coord(int s);
    int r;
    r = $urandom_range(0, 9);
    if (s == 0 || r == 0) return $urandom_range(0, 63);
    if (r == 1) return 0;
    if (r == 2) return s - 1;
    return $urandom_range(0, s - 1);
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("periodic_cell_neighbor_generator: mismatch");
      $finish;
    end
  end

  // Sender: predict on every accepted item.
  always @(posedge clk) begin
    if (rst_n && push && !full) begin
      expand_neighbors(in_item);
      offering = 1'b0;
    end
  end

  always @(negedge clk) begin : drive_requests
    logic nxt_push;
    in_item_t nxt_item;
    nxt_push = push;
    nxt_item = in_item;
    if (!rst_n) begin
      nxt_push = 1'b0;
    end else if (!offering) begin
      nxt_push = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 13);
      end else if (request_q.size() > 0) begin
        nxt_item = request_q.pop_front();
        offering = 1'b1;
        nxt_push = 1'b1;
      end
    end
    push <= nxt_push;
    in_item <= nxt_item;
  end

  always @(negedge clk) begin : drive_pop
    logic nxt_pop;
    nxt_pop = 1'b0;
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
      end else if (holds_req > holds_done) begin
        hold_left = LongHoldCycles - 1;
        holds_done++;
      end else if (recv_gap > 0) begin
        recv_gap--;
      end else if (!calm && $urandom_range(0, 19) == 0) begin
        recv_gap = $urandom_range(0, 13);
      end else begin
        nxt_pop = 1'b1;
      end
    end
    pop <= nxt_pop;
  end

  // Compare each result item with the oldest expectation.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && pop && !empty) begin
      if (neighbor_q.size() == 0) begin
        report_mismatch("result item with nothing expected", int'(out_item.neighbor_index), 0);
      end else begin
        want = neighbor_q.pop_front();
        if (out_item.slot !== want.slot)
          report_mismatch("slot", int'(out_item.slot), int'(want.slot));
        if (out_item.neighbor_index !== want.neighbor_index)
          report_mismatch("neighbor_index", int'(out_item.neighbor_index),
                          int'(want.neighbor_index));
        if (out_item.bad_coordinate !== want.bad_coordinate)
          report_mismatch("bad_coordinate", int'(out_item.bad_coordinate),
                          int'(want.bad_coordinate));
        if (out_item.last !== want.last)
          report_mismatch("last", int'(out_item.last), int'(want.last));
      end
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Reset sizes 8x8x8: corners, interior and each axis out of range.
    queue_cell(0, 0, 0);
    queue_cell(7, 7, 7);
    queue_cell(7, 0, 3);
    queue_cell(0, 7, 0);
    queue_cell(3, 4, 5);
    queue_cell(8, 0, 0);
    queue_cell(0, 8, 0);
    queue_cell(0, 0, 8);
    queue_cell(63, 63, 63);
    wait_drained();

    // Axes of one wrap onto themselves.
    set_sizes(1, 1, 1);
    queue_cell(0, 0, 0);
    queue_cell(1, 0, 0);
    queue_cell(0, 0, 1);
    wait_drained();

    // Zero size rejects everything.
    set_sizes(0, 5, 5);
    queue_cell(0, 0, 0);
    wait_drained();

    set_sizes(64, 64, 64);
    queue_cell(63, 63, 63);
    queue_cell(0, 0, 0);
    queue_cell(63, 0, 31);
    wait_drained();

    // Oversized registers saturate at the axis limit.
    set_sizes(127, 100, 65);
    queue_cell(63, 63, 63);
    queue_cell(0, 63, 0);
    wait_drained();

    // Spare register index must be ignored.
    set_sizes(2, 3, 1);
    write_reg(CfgSpare, 7'h2a);
    write_reg(CfgSpare, 7'h55);
    queue_cell(1, 2, 0);
    queue_cell(0, 0, 0);
    queue_cell(2, 0, 0);
    wait_drained();

    for (int p = 0; p < RandomPhases; p++) begin
      set_sizes(pick_size(), pick_size(), pick_size());
      if (p == RandomPhases - 1) calm = 1'b1;
      for (int n = 0; n < PhaseItems; n++) begin
        queue_cell(pick_coord(clamp_size(size_x_r)), pick_coord(clamp_size(size_y_r)),
                   pick_coord(clamp_size(size_z_r)));
      end
      // Stall the result side long enough for the input to back up.
      if (p == 1) holds_req++;
      wait_drained();
    end

    if (neighbor_q.size() != 0)
      report_mismatch("result items never delivered", 0, neighbor_q.size());
    if (error_count == 0) begin
      $display("periodic_cell_neighbor_generator: match");
    end else begin
      $display("periodic_cell_neighbor_generator: mismatch");
    end
    $finish;
  end

endmodule
